>>> rtl/ellipsoid_rectangle_pushout_top_defines.svh
// Assertion helpers shared by the RTL of the rectangle push-out block.
// The enclosing module must provide clk_i and rst_ni.
`ifndef ELLIPSOID_RECTANGLE_PUSHOUT_TOP_DEFINES_SVH
`define ELLIPSOID_RECTANGLE_PUSHOUT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define ERP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define ERP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/erp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erp_pkg;

  // Fixed field widths.
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RAD_W  = 31;
  localparam int unsigned GRAV_W = 18;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS = 8'd0,
    REG_GRAV_X = 8'd1,
    REG_GRAV_Y = 8'd2,
    REG_GRAV_Z = 8'd3
  } reg_idx_e;

  // Root extraction: 32 result bits, two per stage.
  localparam int unsigned SQRT_PER_STG = 2;
  localparam int unsigned SQRT_STG     = 32 / SQRT_PER_STG;
  // Quotient: 34 bits (clamped), two per stage.
  localparam int unsigned DIV_PER_STG  = 2;
  localparam int unsigned DIV_STG      = 34 / DIV_PER_STG;
  // Nine front stages, two between root and quotient, one output stage.
  localparam int unsigned PIPE_STG     = 12 + SQRT_STG + DIV_STG;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [33:0] quo;
    logic [33:0] num;
  } div_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Magnitude of a 32 bit signed value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? (~x + 32'd1) : x;
    return r;
  endfunction

  // One digit of the square root: brings down two radicand bits.
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t       r;
    logic [34:0] cur;
    logic [34:0] trial;
    cur   = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring division.
  function automatic div_t div_step(input div_t s, input logic [31:0] dv);
    div_t        r;
    logic [32:0] cur;
    cur   = {s.rem[31:0], s.num[33]};
    r.num = {s.num[32:0], 1'b0};
    if (cur >= {1'b0, dv}) begin
      r.rem = cur - {1'b0, dv};
      r.quo = {s.quo[32:0], 1'b1};
    end else begin
      r.rem = cur;
      r.quo = {s.quo[32:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ellipsoid_rectangle_pushout_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Rectangle push-out for an object squashed along gravity. Issue an item by
// raising start_i while busy_o is low; one item is taken every clock cycle and
// each one gives exactly one result, shown for a single cycle with valid_o
// high. The receiver cannot stall, so it must take every result in that
// cycle. The square root (32 root bits, two per stage) and the push divider
// (34 quotient bits, two per stage) sit in series in the pipeline.
// busy_o is high only during reset. Write registers only while no item is in
// flight; cfg_ready_o is always high.

`include "ellipsoid_rectangle_pushout_top_defines.svh"

module ellipsoid_rectangle_pushout_top import erp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [31:0]       pos_z_i,
  input  logic signed [31:0]       rect_origin_x_i,
  input  logic signed [31:0]       rect_origin_y_i,
  input  logic signed [31:0]       rect_origin_z_i,
  input  logic signed [31:0]       rect_size_x_i,
  input  logic signed [31:0]       rect_size_y_i,
  input  logic signed [31:0]       rect_size_z_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IDX_W-1:0]         cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  output logic                     valid_o,
  output logic signed [31:0]       new_pos_x_o,
  output logic signed [31:0]       new_pos_y_o,
  output logic signed [31:0]       new_pos_z_o,
  output logic                     hit_o
);

  localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] NEG_ONE = -ONE;
  localparam logic [RAD_W-1:0]   RAD_RST = ONE[RAD_W-1:0];
  localparam logic [GRAV_W-1:0]  GNEG    = NEG_ONE[GRAV_W-1:0];

  logic accept;
  logic [PIPE_STG-1:0] vld_q;

  // Configuration registers.
  logic [RAD_W-1:0]         radius_q;
  logic signed [GRAV_W-1:0] grav_q [3];

  assign busy_o      = !rst_ni;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RAD_RST;
      grav_q[0] <= '0;
      grav_q[1] <= $signed(GNEG);
      grav_q[2] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RADIUS: radius_q  <= cfg_data_i[RAD_W-1:0];
        REG_GRAV_X: grav_q[0] <= $signed(cfg_data_i[GRAV_W-1:0]);
        REG_GRAV_Y: grav_q[1] <= $signed(cfg_data_i[GRAV_W-1:0]);
        REG_GRAV_Z: grav_q[2] <= $signed(cfg_data_i[GRAV_W-1:0]);
        default: ;
      endcase
    end
  end

  // Valid bits run alongside the data stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_STG-2:0], accept};
    end
  end

  // Stage A: offsets from the corner and the chosen axes.
  logic signed [31:0] s1, s2;
  logic signed [31:0] pa_q [3];
  logic signed [32:0] oa_q [3];
  logic               a1x_q, a2z_q, sg1n_q, sg2n_q;
  logic [31:0]        len1_q, len2_q;

  assign s1 = (rect_size_x_i != '0) ? rect_size_x_i : rect_size_y_i;
  assign s2 = (rect_size_z_i != '0) ? rect_size_z_i : rect_size_y_i;

  always_ff @(posedge clk_i) begin
    pa_q[0] <= pos_x_i;
    pa_q[1] <= pos_y_i;
    pa_q[2] <= pos_z_i;
    oa_q[0] <= 33'(pos_x_i) - 33'(rect_origin_x_i);
    oa_q[1] <= 33'(pos_y_i) - 33'(rect_origin_y_i);
    oa_q[2] <= 33'(pos_z_i) - 33'(rect_origin_z_i);
    a1x_q   <= rect_size_x_i != '0;
    a2z_q   <= rect_size_z_i != '0;
    sg1n_q  <= !(s1 > 32'sd0);
    sg2n_q  <= !(s2 > 32'sd0);
    len1_q  <= mag32(s1);
    len2_q  <= mag32(s2);
  end

  // Stage B: clamp the position into the rectangle along both axes.
  logic signed [32:0] oa1, oa2;
  logic signed [33:0] t1, t2;
  logic [31:0]        xc, yc;
  logic signed [31:0] pb_q [3];
  logic signed [33:0] nego_q [3];
  logic [31:0]        xb_q, yb_q;
  logic               a1xb_q, a2zb_q, sg1nb_q, sg2nb_q;

  always_comb begin
    oa1 = a1x_q ? oa_q[0] : oa_q[1];
    oa2 = a2z_q ? oa_q[2] : oa_q[1];
    t1  = sg1n_q ? -34'(oa1) : 34'(oa1);
    t2  = sg2n_q ? -34'(oa2) : 34'(oa2);
    if (t1 < 34'sd0) begin
      xc = '0;
    end else if (t1 > $signed({2'b00, len1_q})) begin
      xc = len1_q;
    end else begin
      xc = t1[31:0];
    end
    if (t2 < 34'sd0) begin
      yc = '0;
    end else if (t2 > $signed({2'b00, len2_q})) begin
      yc = len2_q;
    end else begin
      yc = t2[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pb_q[i]   <= pa_q[i];
      nego_q[i] <= 34'sd0 - 34'(oa_q[i]);
    end
    xb_q    <= xc;
    yb_q    <= yc;
    a1xb_q  <= a1x_q;
    a2zb_q  <= a2z_q;
    sg1nb_q <= sg1n_q;
    sg2nb_q <= sg2n_q;
  end

  // Stage C: offset to the closest point, saturated.
  logic signed [33:0] xs, ys, sx1, sy2;
  logic signed [35:0] vs [3];
  logic signed [31:0] pc_q [3];
  logic signed [31:0] vc_q [3];

  always_comb begin
    xs    = $signed({2'b00, xb_q});
    ys    = $signed({2'b00, yb_q});
    sx1   = sg1nb_q ? -xs : xs;
    sy2   = sg2nb_q ? -ys : ys;
    vs[0] = 36'(nego_q[0]) + (a1xb_q ? 36'(sx1) : 36'sd0);
    vs[1] = 36'(nego_q[1]) + (!a1xb_q ? 36'(sx1) : 36'sd0)
          + (!a2zb_q ? 36'(sy2) : 36'sd0);
    vs[2] = 36'(nego_q[2]) + (a2zb_q ? 36'(sy2) : 36'sd0);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pc_q[i] <= pb_q[i];
      vc_q[i] <= sat32(64'(vs[i]));
    end
  end

  // Stage D: gravity dot products.
  logic signed [31:0] pd_q [3];
  logic signed [31:0] vd_q [3];
  logic signed [49:0] gp_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pd_q[i] <= pc_q[i];
      vd_q[i] <= vc_q[i];
      gp_q[i] <= 50'(vc_q[i]) * 50'(grav_q[i]);
    end
  end

  // Stage E: gravity component.
  logic signed [51:0] gsum, gsh;
  logic signed [31:0] pe_q [3];
  logic signed [31:0] ve_q [3];
  logic signed [31:0] gval_q;

  assign gsum = 52'(gp_q[0]) + 52'(gp_q[1]) + 52'(gp_q[2]);
  assign gsh  = gsum >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pe_q[i] <= pd_q[i];
      ve_q[i] <= vd_q[i];
    end
    gval_q <= sat32(64'(gsh));
  end

  // Stage F: gravity part of the offset and the squared gravity term.
  logic [31:0]        gm;
  logic signed [31:0] pf_q [3];
  logic signed [31:0] vf_q [3];
  logic signed [49:0] gg_q [3];
  logic [63:0]        gsq_q;

  assign gm = mag32(gval_q);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pf_q[i] <= pe_q[i];
      vf_q[i] <= ve_q[i];
      gg_q[i] <= 50'(grav_q[i]) * 50'(gval_q);
    end
    gsq_q <= (64'(gm) * 64'(gm)) >> 2;
  end

  // Stage G: remainder perpendicular to gravity.
  logic signed [50:0] dv [3];
  logic signed [31:0] pg_q [3];
  logic signed [31:0] vg_q [3];
  logic [31:0]        mg_q [3];
  logic [63:0]        gsqg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = 51'(vf_q[i]) - 51'(gg_q[i] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pg_q[i] <= pf_q[i];
      vg_q[i] <= vf_q[i];
      mg_q[i] <= mag32(sat32(64'(dv[i])));
    end
    gsqg_q <= gsq_q;
  end

  // Stage H: squares.
  logic signed [31:0] ph_q [3];
  logic signed [31:0] vh_q [3];
  logic [63:0]        sq_h_q [3];
  logic [63:0]        gsqh_q;
  logic [63:0]        rr_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ph_q[i]   <= pg_q[i];
      vh_q[i]   <= vg_q[i];
      sq_h_q[i] <= 64'(mg_q[i]) * 64'(mg_q[i]);
    end
    gsqh_q <= gsqg_q;
    rr_q   <= 64'(radius_q) * 64'(radius_q);
  end

  // Stage I: squared distance and hit test; feeds the root pipeline.
  logic [63:0]        sqd;
  sqrt_t              sr_q [SQRT_STG+1];
  logic signed [31:0] sp_q [SQRT_STG+1][3];
  logic signed [31:0] sv_q [SQRT_STG+1][3];
  logic               shit_q [SQRT_STG+1];

  assign sqd = sq_h_q[0] + sq_h_q[1] + sq_h_q[2] + gsqh_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sp_q[0][i] <= ph_q[i];
      sv_q[0][i] <= vh_q[i];
    end
    sr_q[0]   <= '{rem: '0, root: '0, rad: sqd};
    shit_q[0] <= sqd < rr_q;
  end

  // Square root, two result bits per stage.
  for (genvar s = 0; s < SQRT_STG; s++) begin : g_sqrt
    sqrt_t sw [SQRT_PER_STG+1];

    always_comb begin
      sw[0] = sr_q[s];
      for (int j = 0; j < SQRT_PER_STG; j++) begin
        sw[j+1] = sqrt_step(sw[j]);
      end
    end

    always_ff @(posedge clk_i) begin
      sr_q[s+1]   <= sw[SQRT_PER_STG];
      shit_q[s+1] <= shit_q[s];
      for (int i = 0; i < 3; i++) begin
        sp_q[s+1][i] <= sp_q[s][i];
        sv_q[s+1][i] <= sv_q[s][i];
      end
    end
  end

  // Stage K: push length numerators and the divisor.
  logic [31:0]        droot, kk;
  logic signed [31:0] pk_q [3];
  logic               vpk_q [3];
  logic [62:0]        num_q [3];
  logic [31:0]        dvk_q;
  logic               hitk_q, dzk_q;

  assign droot = sr_q[SQRT_STG].root;
  assign kk    = 32'(radius_q) - droot;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pk_q[i]  <= sp_q[SQRT_STG][i];
      vpk_q[i] <= sv_q[SQRT_STG][i] > 32'sd0;
      num_q[i] <= 63'(mag32(sv_q[SQRT_STG][i])) * 63'(kk[RAD_W-1:0]);
    end
    dvk_q  <= (droot == '0) ? 32'd1 : droot;
    hitk_q <= shit_q[SQRT_STG];
    dzk_q  <= droot == '0;
  end

  // Stage L: overflow check and divider load.
  div_t               dr_q [DIV_STG+1][3];
  logic               ovf_q [DIV_STG+1][3];
  logic               dvp_q [DIV_STG+1][3];
  logic signed [31:0] dp_q [DIV_STG+1][3];
  logic [31:0]        dd_q [DIV_STG+1];
  logic               dhit_q [DIV_STG+1];
  logic               ddz_q [DIV_STG+1];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dr_q[0][i]  <= '{rem: 33'(num_q[i][62:34]), quo: '0, num: num_q[i][33:0]};
      ovf_q[0][i] <= 32'(num_q[i][62:34]) >= dvk_q;
      dvp_q[0][i] <= vpk_q[i];
      dp_q[0][i]  <= pk_q[i];
    end
    dd_q[0]   <= dvk_q;
    dhit_q[0] <= hitk_q;
    ddz_q[0]  <= dzk_q;
  end

  // Divider, two quotient bits per stage for each axis.
  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    div_t dw [3][DIV_PER_STG+1];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        dw[i][0] = dr_q[s][i];
        for (int j = 0; j < DIV_PER_STG; j++) begin
          dw[i][j+1] = div_step(dw[i][j], dd_q[s]);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[s+1][i]  <= dw[i][DIV_PER_STG];
        ovf_q[s+1][i] <= ovf_q[s][i];
        dvp_q[s+1][i] <= dvp_q[s][i];
        dp_q[s+1][i]  <= dp_q[s][i];
      end
      dd_q[s+1]   <= dd_q[s];
      dhit_q[s+1] <= dhit_q[s];
      ddz_q[s+1]  <= ddz_q[s];
    end
  end

  // Stage M: apply the push and saturate.
  logic [33:0]        qv [3];
  logic signed [35:0] qs [3];
  logic signed [35:0] psum [3];
  logic signed [31:0] np [3];
  logic               push;
  logic signed [31:0] out_q [3];
  logic               hit_q;

  assign push = dhit_q[DIV_STG] && !ddz_q[DIV_STG];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i]   = ovf_q[DIV_STG][i] ? '1 : dr_q[DIV_STG][i].quo;
      qs[i]   = $signed({2'b00, qv[i]});
      psum[i] = 36'(dp_q[DIV_STG][i]) + (dvp_q[DIV_STG][i] ? -qs[i] : qs[i]);
      np[i]   = push ? sat32(64'(psum[i])) : dp_q[DIV_STG][i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      out_q[i] <= np[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= vld_q[PIPE_STG-2] && dhit_q[DIV_STG];
    end
  end

  assign valid_o     = vld_q[PIPE_STG-1];
  assign new_pos_x_o = out_q[0];
  assign new_pos_y_o = out_q[1];
  assign new_pos_z_o = out_q[2];
  assign hit_o       = hit_q;

  // Checks.
  `ERP_ASSERT_IMPL(a_result_has_issue, valid_o, $past(accept, PIPE_STG),
                   "result without a matching item")
  `ERP_ASSERT_IMPL(a_miss_keeps_pos, valid_o && !hit_o,
                   new_pos_x_o == $past(pos_x_i, PIPE_STG) &&
                   new_pos_y_o == $past(pos_y_i, PIPE_STG) &&
                   new_pos_z_o == $past(pos_z_i, PIPE_STG),
                   "position moved without a hit")
  `ERP_ASSERT_IMPL(a_hit_only_valid, !valid_o, !hit_o, "hit outside a result")

endmodule

`default_nettype wire
